// File: hw/rtl/fed_pkg.sv
// shared types and constants of the fall event detector
package fed_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_CAND   = 3'd1,
    PH_IMPACT = 3'd2,
    PH_ORIENT = 3'd3,
    PH_REST   = 3'd4,
    PH_FALL   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CFG_CAND_MAG   = 3'd0,
    CFG_IMPACT_MAG = 3'd1,
    CFG_ORIENT_COS = 3'd2,
    CFG_REST_LOW   = 3'd3,
    CFG_REST_HIGH  = 3'd4
  } cfg_reg_e;

  // multiplier steps, run in this order
  typedef enum logic [3:0] {
    OP_MAG_X    = 4'd0,
    OP_MAG_Y    = 4'd1,
    OP_MAG_Z    = 4'd2,
    OP_DOT_X    = 4'd3,
    OP_DOT_Y    = 4'd4,
    OP_DOT_Z    = 4'd5,
    OP_DOT_SQ   = 4'd6,
    OP_MAG_PROD = 4'd7,
    OP_COS_SQ   = 4'd8,
    OP_FAR_LO   = 4'd9,
    OP_FAR_HI   = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_MUL      = 3'd2,
    ST_ACC      = 3'd3,
    ST_CMP      = 3'd4,
    ST_COMMIT   = 3'd5
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    op_e  op;
    logic cmp;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic rearm;
  } sts_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned COS_W      = 16;
  localparam int unsigned COS_FRAC   = 14;
  localparam int unsigned COS_SQ_SHIFT = 2 * COS_FRAC;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CONF_W     = 7;

  localparam logic signed [COS_W-1:0] COS_ONE    = 16'sd16384;
  localparam logic [CONF_W-1:0]        CONF_PCT   = 7'd88;
  localparam int                       ONE_G      = 4096;

  localparam logic [THR_W-1:0]         CAND_MAG_RST   = 32'd67108864;
  localparam logic [THR_W-1:0]         IMPACT_MAG_RST = 32'd150994944;
  localparam logic signed [COS_W-1:0] ORIENT_COS_RST = 16'sd8192;
  localparam logic [THR_W-1:0]         REST_LOW_RST   = 32'd8219689;
  localparam logic [THR_W-1:0]         REST_HIGH_RST  = 32'd28355625;

endpackage

// File: hw/rtl/fed_ctrl.sv
// sequencing state machine of the fall event detector
module fed_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fed_pkg::sts_t sts_i,
  output fed_pkg::cmd_t cmd_o
);

  fed_pkg::state_e state_q, state_d;
  fed_pkg::op_e    op_q, op_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      fed_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fed_pkg::ST_DISPATCH;
        end
      end
      fed_pkg::ST_DISPATCH: begin
        op_d = fed_pkg::OP_MAG_X;
        if (sts_i.rearm) begin
          state_d = fed_pkg::ST_COMMIT;
        end else begin
          state_d = fed_pkg::ST_MUL;
        end
      end
      fed_pkg::ST_MUL: begin
        state_d = fed_pkg::ST_ACC;
      end
      fed_pkg::ST_ACC: begin
        if (op_q == fed_pkg::OP_FAR_HI) begin
          state_d = fed_pkg::ST_CMP;
        end else begin
          op_d    = fed_pkg::op_e'(op_q + 4'd1);
          state_d = fed_pkg::ST_MUL;
        end
      end
      fed_pkg::ST_CMP: begin
        state_d = fed_pkg::ST_COMMIT;
      end
      fed_pkg::ST_COMMIT: begin
        if (slot_free) begin
          state_d = fed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fed_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_q;
    cmd_o.load   = (state_q == fed_pkg::ST_IDLE) && in_valid_i;
    cmd_o.mul    = (state_q == fed_pkg::ST_MUL);
    cmd_o.acc    = (state_q == fed_pkg::ST_ACC);
    cmd_o.cmp    = (state_q == fed_pkg::ST_CMP);
    cmd_o.commit = (state_q == fed_pkg::ST_COMMIT) && slot_free;
    in_ready_o   = (state_q == fed_pkg::ST_IDLE);
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fed_pkg::ST_IDLE;
      op_q        <= fed_pkg::OP_MAG_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/fed_datapath.sv
// shared multiplier, detector state, configuration and result registers
module fed_datapath #(
  parameter int SAMPLE_WIDTH         = 16,
  parameter int TIME_WIDTH           = 32,
  parameter int CANDIDATE_TIMEOUT_MS = 500,
  parameter int IMPACT_TIMEOUT_MS    = 1000,
  parameter int REST_HOLD_MS         = 1500,
  parameter int REST_TIMEOUT_MS      = 3000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fed_pkg::cmd_t                     cmd_i,
  output fed_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [fed_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fed_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              func_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_z_i,
  input  logic [TIME_WIDTH-1:0]             time_ms_i,
  output logic [fed_pkg::PHASE_W-1:0]       phase_o,
  output logic                              fall_event_o,
  output logic [fed_pkg::CONF_W-1:0]        confidence_pct_o
);

  localparam int MAG_W  = 2 * SAMPLE_WIDTH;
  localparam int MUL_W  = (MAG_W > 32) ? MAG_W : 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FAR_W  = 3 * MUL_W;
  localparam int DOT_W  = MAG_W + 1;

  localparam logic signed [SAMPLE_WIDTH-1:0] Z_RST   = SAMPLE_WIDTH'(fed_pkg::ONE_G);
  localparam logic [MAG_W-1:0]               MAG_RST =
    MAG_W'(fed_pkg::ONE_G * fed_pkg::ONE_G);

  function automatic logic [SAMPLE_WIDTH-1:0] abs_s(input logic signed [SAMPLE_WIDTH-1:0] v);
    logic [SAMPLE_WIDTH-1:0] r;
    r = v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-v) : v;
    return r;
  endfunction

  // configuration
  logic [fed_pkg::THR_W-1:0]        cand_thr_q, impact_thr_q, rest_low_q, rest_high_q;
  logic signed [fed_pkg::COS_W-1:0] cos_q;

  // captured request
  logic                           func_q;
  logic signed [SAMPLE_WIDTH-1:0] vx_q, vy_q, vz_q;
  logic [TIME_WIDTH-1:0]          t_q;

  // detector state
  fed_pkg::phase_e                phase_q, phase_d;
  logic signed [SAMPLE_WIDTH-1:0] base_x_q, base_y_q, base_z_q;
  logic signed [SAMPLE_WIDTH-1:0] imp_x_q, imp_y_q, imp_z_q;
  logic [MAG_W-1:0]               base_mag_q, imp_mag_q;
  logic [TIME_WIDTH-1:0]          cand_t_q, cand_t_d, imp_t_q, imp_t_d, rest_t_q, rest_t_d;
  logic                           conf_q, conf_d;
  logic                           take_base, take_imp, fall_event_d;

  // arithmetic
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic                    mul_neg;
  logic [PROD_W-1:0]       mul_p, prod_q;
  logic [MAG_W-1:0]        mag_q;
  logic signed [DOT_W-1:0] dot_q, dot_neg, prod_term;
  logic [MAG_W-1:0]        dot_abs;
  logic [fed_pkg::COS_W-1:0] cos_abs;
  logic [PROD_W-1:0]       dsq_q, mp_q;
  logic [MUL_W-1:0]        csq_q;
  logic [FAR_W-1:0]        far_q, lhs;
  logic                    dot_pos, orient_q, orient_d;

  // results
  fed_pkg::phase_e           out_phase_q;
  logic                      out_event_q;
  logic [fed_pkg::CONF_W-1:0] out_conf_q;

  assign sts_o.rearm = func_q;

  assign dot_neg = -dot_q;
  assign dot_abs = dot_q[DOT_W-1] ? dot_neg[MAG_W-1:0] : dot_q[MAG_W-1:0];
  assign cos_abs = cos_q[fed_pkg::COS_W-1] ? fed_pkg::COS_W'(-cos_q) : cos_q;

  // operand select for the one multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      fed_pkg::OP_MAG_X: begin
        mul_a = MUL_W'(abs_s(vx_q));
        mul_b = MUL_W'(abs_s(vx_q));
      end
      fed_pkg::OP_MAG_Y: begin
        mul_a = MUL_W'(abs_s(vy_q));
        mul_b = MUL_W'(abs_s(vy_q));
      end
      fed_pkg::OP_MAG_Z: begin
        mul_a = MUL_W'(abs_s(vz_q));
        mul_b = MUL_W'(abs_s(vz_q));
      end
      fed_pkg::OP_DOT_X: begin
        mul_a   = MUL_W'(abs_s(base_x_q));
        mul_b   = MUL_W'(abs_s(imp_x_q));
        mul_neg = base_x_q[SAMPLE_WIDTH-1] ^ imp_x_q[SAMPLE_WIDTH-1];
      end
      fed_pkg::OP_DOT_Y: begin
        mul_a   = MUL_W'(abs_s(base_y_q));
        mul_b   = MUL_W'(abs_s(imp_y_q));
        mul_neg = base_y_q[SAMPLE_WIDTH-1] ^ imp_y_q[SAMPLE_WIDTH-1];
      end
      fed_pkg::OP_DOT_Z: begin
        mul_a   = MUL_W'(abs_s(base_z_q));
        mul_b   = MUL_W'(abs_s(imp_z_q));
        mul_neg = base_z_q[SAMPLE_WIDTH-1] ^ imp_z_q[SAMPLE_WIDTH-1];
      end
      fed_pkg::OP_DOT_SQ: begin
        mul_a = MUL_W'(dot_abs);
        mul_b = MUL_W'(dot_abs);
      end
      fed_pkg::OP_MAG_PROD: begin
        mul_a = MUL_W'(base_mag_q);
        mul_b = MUL_W'(imp_mag_q);
      end
      fed_pkg::OP_COS_SQ: begin
        mul_a = MUL_W'(cos_abs);
        mul_b = MUL_W'(cos_abs);
      end
      fed_pkg::OP_FAR_LO: begin
        mul_a = csq_q;
        mul_b = mp_q[MUL_W-1:0];
      end
      fed_pkg::OP_FAR_HI: begin
        mul_a = csq_q;
        mul_b = mp_q[PROD_W-1:MUL_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign prod_term = DOT_W'({1'b0, prod_q[MAG_W-1:0]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= mul_p;
    end
    if (cmd_i.acc) begin
      case (cmd_i.op)
        fed_pkg::OP_MAG_X:    mag_q <= prod_q[MAG_W-1:0];
        fed_pkg::OP_MAG_Y,
        fed_pkg::OP_MAG_Z:    mag_q <= mag_q + prod_q[MAG_W-1:0];
        fed_pkg::OP_DOT_X:    dot_q <= mul_neg ? -prod_term : prod_term;
        fed_pkg::OP_DOT_Y,
        fed_pkg::OP_DOT_Z:    dot_q <= mul_neg ? dot_q - prod_term : dot_q + prod_term;
        fed_pkg::OP_DOT_SQ:   dsq_q <= prod_q;
        fed_pkg::OP_MAG_PROD: mp_q  <= prod_q;
        fed_pkg::OP_COS_SQ:   csq_q <= prod_q[MUL_W-1:0];
        fed_pkg::OP_FAR_LO:   far_q <= {{MUL_W{1'b0}}, prod_q};
        fed_pkg::OP_FAR_HI:   far_q <= far_q + {prod_q, {MUL_W{1'b0}}};
        default: begin
        end
      endcase
    end
    if (cmd_i.cmp) begin
      orient_q <= orient_d;
    end
  end

  // angle test: dot^2 * 2^28 against cos^2 * |b|^2 * |i|^2, sign handled apart
  assign lhs     = {{(MUL_W - fed_pkg::COS_SQ_SHIFT){1'b0}}, dsq_q,
                    {fed_pkg::COS_SQ_SHIFT{1'b0}}};
  assign dot_pos = !dot_q[DOT_W-1] && (dot_q != '0);

  always_comb begin
    if (base_mag_q == '0 || imp_mag_q == '0) begin
      orient_d = (cos_q >= fed_pkg::COS_ONE);
    end else if (!dot_pos && !cos_q[fed_pkg::COS_W-1]) begin
      orient_d = 1'b1;
    end else if (dot_pos && (cos_q[fed_pkg::COS_W-1] || cos_q == '0)) begin
      orient_d = 1'b0;
    end else if (dot_pos) begin
      orient_d = (lhs <= far_q);
    end else begin
      orient_d = (lhs >= far_q);
    end
  end

  // phase walk on commit
  logic [MUL_W-1:0]      s_ext;
  logic [TIME_WIDTH-1:0] cand_el, imp_el, rest_el;
  logic                  in_band;

  assign s_ext   = MUL_W'(mag_q);
  assign cand_el = t_q - cand_t_q;
  assign imp_el  = t_q - imp_t_q;
  assign rest_el = t_q - rest_t_q;
  assign in_band = (s_ext >= MUL_W'(rest_low_q)) && (s_ext <= MUL_W'(rest_high_q));

  always_comb begin
    phase_d      = phase_q;
    cand_t_d     = cand_t_q;
    imp_t_d      = imp_t_q;
    rest_t_d     = rest_t_q;
    conf_d       = conf_q;
    take_base    = 1'b0;
    take_imp     = 1'b0;
    fall_event_d = 1'b0;
    if (func_q) begin
      phase_d  = fed_pkg::PH_NORMAL;
      cand_t_d = '0;
      imp_t_d  = '0;
      rest_t_d = '0;
      conf_d   = 1'b0;
    end else begin
      case (phase_q)
        fed_pkg::PH_NORMAL: begin
          take_base = 1'b1;
          if (s_ext >= MUL_W'(cand_thr_q)) begin
            phase_d  = fed_pkg::PH_CAND;
            cand_t_d = t_q;
          end
        end
        fed_pkg::PH_CAND: begin
          if (s_ext >= MUL_W'(impact_thr_q)) begin
            phase_d  = fed_pkg::PH_IMPACT;
            take_imp = 1'b1;
            imp_t_d  = t_q;
          end else if (cand_el > TIME_WIDTH'(CANDIDATE_TIMEOUT_MS)) begin
            phase_d  = fed_pkg::PH_NORMAL;
            cand_t_d = '0;
            imp_t_d  = '0;
            rest_t_d = '0;
            conf_d   = 1'b0;
          end
        end
        fed_pkg::PH_IMPACT: begin
          if (orient_q) begin
            phase_d  = fed_pkg::PH_ORIENT;
            rest_t_d = t_q;
          end else if (imp_el > TIME_WIDTH'(IMPACT_TIMEOUT_MS)) begin
            phase_d  = fed_pkg::PH_NORMAL;
            cand_t_d = '0;
            imp_t_d  = '0;
            rest_t_d = '0;
            conf_d   = 1'b0;
          end
        end
        fed_pkg::PH_ORIENT: begin
          phase_d = fed_pkg::PH_REST;
        end
        fed_pkg::PH_REST: begin
          if (in_band) begin
            if (rest_el >= TIME_WIDTH'(REST_HOLD_MS)) begin
              phase_d      = fed_pkg::PH_FALL;
              conf_d       = 1'b1;
              fall_event_d = 1'b1;
            end
          end else if (rest_el > TIME_WIDTH'(REST_TIMEOUT_MS)) begin
            phase_d  = fed_pkg::PH_NORMAL;
            cand_t_d = '0;
            imp_t_d  = '0;
            rest_t_d = '0;
            conf_d   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      vx_q   <= accel_x_i;
      vy_q   <= accel_y_i;
      vz_q   <= accel_z_i;
      t_q    <= time_ms_i;
    end
    if (cmd_i.commit) begin
      out_phase_q <= phase_d;
      out_event_q <= fall_event_d;
      out_conf_q  <= conf_d ? fed_pkg::CONF_PCT : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fed_pkg::PH_NORMAL;
      cand_t_q   <= '0;
      imp_t_q    <= '0;
      rest_t_q   <= '0;
      conf_q     <= 1'b0;
      base_x_q   <= '0;
      base_y_q   <= '0;
      base_z_q   <= Z_RST;
      imp_x_q    <= '0;
      imp_y_q    <= '0;
      imp_z_q    <= Z_RST;
      base_mag_q <= MAG_RST;
      imp_mag_q  <= MAG_RST;
    end else if (cmd_i.commit) begin
      phase_q  <= phase_d;
      cand_t_q <= cand_t_d;
      imp_t_q  <= imp_t_d;
      rest_t_q <= rest_t_d;
      conf_q   <= conf_d;
      if (take_base) begin
        base_x_q   <= vx_q;
        base_y_q   <= vy_q;
        base_z_q   <= vz_q;
        base_mag_q <= mag_q;
      end
      if (take_imp) begin
        imp_x_q   <= vx_q;
        imp_y_q   <= vy_q;
        imp_z_q   <= vz_q;
        imp_mag_q <= mag_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_thr_q   <= fed_pkg::CAND_MAG_RST;
      impact_thr_q <= fed_pkg::IMPACT_MAG_RST;
      cos_q        <= fed_pkg::ORIENT_COS_RST;
      rest_low_q   <= fed_pkg::REST_LOW_RST;
      rest_high_q  <= fed_pkg::REST_HIGH_RST;
    end else if (cfg_we_i) begin
      case (fed_pkg::cfg_reg_e'(cfg_index_i))
        fed_pkg::CFG_CAND_MAG:   cand_thr_q   <= cfg_data_i;
        fed_pkg::CFG_IMPACT_MAG: impact_thr_q <= cfg_data_i;
        fed_pkg::CFG_ORIENT_COS: cos_q        <= cfg_data_i[fed_pkg::COS_W-1:0];
        fed_pkg::CFG_REST_LOW:   rest_low_q   <= cfg_data_i;
        fed_pkg::CFG_REST_HIGH:  rest_high_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign phase_o          = out_phase_q;
  assign fall_event_o     = out_event_q;
  assign confidence_pct_o = out_conf_q;

endmodule

// File: hw/rtl/fall_event_detector.sv
// top level of the fall event detector
//
// Input channel (in_valid_i / in_ready_o) takes one request per item: a sample
// (func_i = 0) with three acceleration axes at 4096 per g and a millisecond
// timestamp, or a rearm (func_i = 1). Every request gives exactly one result
// on the output channel (out_valid_o / out_ready_i): the phase after the
// request, a one-request fall_event_o pulse on entry to possible fall, and the
// confidence (0 or 88).
// A sample runs a dispatch state, eleven multiply steps (a multiply and an
// accumulate state each) on one shared multiplier, a compare state and a
// commit state; a new request is taken only in idle. A rearm goes from
// dispatch straight to commit. The result register frees the input side: a
// new request is accepted while an earlier result still waits. If the
// receiver stalls, the following request finishes its arithmetic and waits
// at commit until the result register empties.
// Configuration writes (cfg_valid_i, always ready) are to be made by the user
// only while no request is in flight; the block does not enforce this. Reset
// returns thresholds to defaults, phase to normal, both stored vectors to one
// g along z and clears the output valid.
module fall_event_detector #(
  parameter int SAMPLE_WIDTH         = 16,
  parameter int TIME_WIDTH           = 32,
  parameter int CANDIDATE_TIMEOUT_MS = 500,
  parameter int IMPACT_TIMEOUT_MS    = 1000,
  parameter int REST_HOLD_MS         = 1500,
  parameter int REST_TIMEOUT_MS      = 3000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic [TIME_WIDTH-1:0]          time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fed_pkg::PHASE_W-1:0]    phase_o,
  output logic                           fall_event_o,
  output logic [fed_pkg::CONF_W-1:0]     confidence_pct_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fed_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fed_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fed_pkg::cmd_t cmd;
  fed_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  fed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fed_datapath #(
    .SAMPLE_WIDTH         (SAMPLE_WIDTH),
    .TIME_WIDTH           (TIME_WIDTH),
    .CANDIDATE_TIMEOUT_MS (CANDIDATE_TIMEOUT_MS),
    .IMPACT_TIMEOUT_MS    (IMPACT_TIMEOUT_MS),
    .REST_HOLD_MS         (REST_HOLD_MS),
    .REST_TIMEOUT_MS      (REST_TIMEOUT_MS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .time_ms_i        (time_ms_i),
    .phase_o          (phase_o),
    .fall_event_o     (fall_event_o),
    .confidence_pct_o (confidence_pct_o)
  );

endmodule

// File: hw/rtl/fed_checker.sv
// port-level checks of the fall event detector and their binding
module fed_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [fed_pkg::PHASE_W-1:0] phase_o,
  input logic                        fall_event_o,
  input logic [fed_pkg::CONF_W-1:0]  confidence_pct_o
);

  // a result waiting on the receiver holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o)
      && $stable(fall_event_o) && $stable(confidence_pct_o))
    else $error("result dropped or changed while stalled");

  a_event_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fall_event_o |-> phase_o == fed_pkg::PH_FALL)
    else $error("fall event outside possible fall phase");

  a_conf_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> confidence_pct_o == fed_pkg::CONF_PCT || confidence_pct_o == '0)
    else $error("confidence neither zero nor full");

  // confidence is latched exactly while in possible fall
  a_conf_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o == fed_pkg::PH_FALL) == (confidence_pct_o == fed_pkg::CONF_PCT))
    else $error("confidence does not match phase");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> phase_o <= fed_pkg::PH_FALL)
    else $error("unused phase code reported");

endmodule

bind fall_event_detector fed_checker u_fed_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .phase_o          (phase_o),
  .fall_event_o     (fall_event_o),
  .confidence_pct_o (confidence_pct_o)
);

// File: verif/tb_fall_event_detector.sv
// testbench for the fall event detector: phase walk, thresholds and timeouts
`timescale 1ns / 1ps

module tb_fall_event_detector;
  import fed_pkg::*;

  localparam int unsigned CAND_TIMEOUT_MS   = 500;
  localparam int unsigned IMPACT_TIMEOUT_MS = 1000;
  localparam int unsigned REST_HOLD_MS      = 1500;
  localparam int unsigned REST_TIMEOUT_MS   = 3000;
  localparam logic [THR_W-1:0] THR_MAX = 32'd3221225472;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } accel_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               fall_event;
    logic [CONF_W-1:0]  confidence;
  } phase_report_t;

  typedef enum int {
    VK_ZERO    = 0,
    VK_REST    = 1,
    VK_STRONG  = 2,
    VK_IMPACT  = 3,
    VK_EXTREME = 4,
    VK_ANY     = 5
  } vec_kind_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    func_i;
  logic signed [15:0]      accel_x_i;
  logic signed [15:0]      accel_y_i;
  logic signed [15:0]      accel_z_i;
  logic [31:0]             time_ms_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [PHASE_W-1:0]      phase_o;
  logic                    fall_event_o;
  logic [CONF_W-1:0]       confidence_pct_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  fall_event_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .phase_o          (phase_o),
    .fall_event_o     (fall_event_o),
    .confidence_pct_o (confidence_pct_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // detector state as predicted
  phase_e             fall_phase;
  accel_t             base_vec;
  accel_t             hit_vec;
  logic [31:0]        cand_ms;
  logic [31:0]        hit_ms;
  logic [31:0]        rest_ms;
  logic               confident;
  logic [THR_W-1:0]   cand_thr;
  logic [THR_W-1:0]   hit_thr;
  logic [THR_W-1:0]   low_thr;
  logic [THR_W-1:0]   high_thr;
  logic signed [15:0] cos_thr;

  phase_report_t phase_report_q[$];
  phase_report_t want;
  accel_t        seen_vec;
  int            fail_count;
  bit            idle_on;
  int            stall_left;
  int            zero_bias_pct;
  logic [31:0]   now_ms;

  always #1 clk_i = ~clk_i;

  function automatic longint sx(logic [15:0] a);
    return longint'(signed'(a));
  endfunction

  function automatic longint unsigned mag_sq(accel_t v);
    return sx(v.x) * sx(v.x) + sx(v.y) * sx(v.y) + sx(v.z) * sx(v.z);
  endfunction

  function automatic accel_t axes(int x, int y, int z);
    accel_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.z = 16'(z);
    return v;
  endfunction

  // angle between baseline and impact at or beyond the threshold, exact in integers
  function automatic bit orientation_turned();
    logic [127:0]    lhs;
    logic [127:0]    rhs;
    longint unsigned s_base;
    longint unsigned s_hit;
    longint          dot;
    longint          cval;
    s_base = mag_sq(base_vec);
    s_hit  = mag_sq(hit_vec);
    cval   = longint'(cos_thr);
    if (s_base == 0 || s_hit == 0) return cval >= longint'(COS_ONE);
    dot = sx(base_vec.x) * sx(hit_vec.x) + sx(base_vec.y) * sx(hit_vec.y)
        + sx(base_vec.z) * sx(hit_vec.z);
    if (dot <= 0 && cval >= 0) return 1'b1;
    if (dot > 0 && cval <= 0) return 1'b0;
    lhs = (dot < 0) ? -dot : dot;
    lhs = lhs * lhs;
    lhs = lhs << COS_SQ_SHIFT;
    rhs = (cval < 0) ? -cval : cval;
    rhs = rhs * rhs;
    rhs = rhs * s_base;
    rhs = rhs * s_hit;
    if (dot > 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  function automatic void clear_detector();
    fall_phase = PH_NORMAL;
    confident  = 1'b0;
    cand_ms    = '0;
    hit_ms     = '0;
    rest_ms    = '0;
  endfunction

  function automatic void advance_detector(logic is_rearm, accel_t v, logic [31:0] t);
    phase_report_t   rep;
    longint unsigned mag;
    logic [31:0]     since_cand;
    logic [31:0]     since_hit;
    logic [31:0]     since_rest;
    rep.fall_event = 1'b0;
    since_cand = t - cand_ms;
    since_hit  = t - hit_ms;
    since_rest = t - rest_ms;
    if (is_rearm) begin
      clear_detector();
    end else begin
      mag = mag_sq(v);
      case (fall_phase)
        PH_NORMAL: begin
          base_vec = v;
          if (mag >= cand_thr) begin
            fall_phase = PH_CAND;
            cand_ms = t;
          end
        end
        PH_CAND: begin
          if (mag >= hit_thr) begin
            fall_phase = PH_IMPACT;
            hit_vec = v;
            hit_ms = t;
          end else if (since_cand > CAND_TIMEOUT_MS) begin
            clear_detector();
          end
        end
        PH_IMPACT: begin
          if (orientation_turned()) begin
            fall_phase = PH_ORIENT;
            rest_ms = t;
          end else if (since_hit > IMPACT_TIMEOUT_MS) begin
            clear_detector();
          end
        end
        PH_ORIENT: fall_phase = PH_REST;
        PH_REST: begin
          if (mag >= low_thr && mag <= high_thr) begin
            if (since_rest >= REST_HOLD_MS) begin
              fall_phase = PH_FALL;
              confident = 1'b1;
              rep.fall_event = 1'b1;
            end
          end else if (since_rest > REST_TIMEOUT_MS) begin
            clear_detector();
          end
        end
        default: ;
      endcase
    end
    rep.phase = fall_phase;
    rep.confidence = confident ? CONF_PCT : '0;
    phase_report_q.push_back(rep);
  endfunction

  task automatic reset_model();
    cand_thr = CAND_MAG_RST;
    hit_thr  = IMPACT_MAG_RST;
    cos_thr  = ORIENT_COS_RST;
    low_thr  = REST_LOW_RST;
    high_thr = REST_HIGH_RST;
    base_vec = axes(0, 0, ONE_G);
    hit_vec  = base_vec;
    clear_detector();
  endtask

  // accepted requests feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen_vec.x = accel_x_i;
      seen_vec.y = accel_y_i;
      seen_vec.z = accel_z_i;
      advance_detector(func_i, seen_vec, time_ms_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CAND_MAG:   cand_thr = cfg_data_i;
        CFG_IMPACT_MAG: hit_thr  = cfg_data_i;
        CFG_ORIENT_COS: cos_thr  = cfg_data_i[COS_W-1:0];
        CFG_REST_LOW:   low_thr  = cfg_data_i;
        CFG_REST_HIGH:  high_thr = cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (phase_report_q.size() == 0) begin
        $error("result with no request pending: phase %0d", phase_o);
        fail_count++;
      end else begin
        want = phase_report_q.pop_front();
        if (phase_o !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, phase_o);
          fail_count++;
        end
        if (fall_event_o !== want.fall_event) begin
          $error("fall_event: expected %0d, got %0d", want.fall_event, fall_event_o);
          fail_count++;
        end
        if (confidence_pct_o !== want.confidence) begin
          $error("confidence_pct: expected %0d, got %0d", want.confidence,
                 confidence_pct_o);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls: mostly short, now and then long
  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic accel_t pick_vector(vec_kind_e kind);
    logic [15:0] axis [3];
    int          spread;
    int          lo;
    int          hi;
    int          lead;
    int          mag;
    accel_t      v;
    if ($urandom_range(0, 99) < zero_bias_pct) kind = VK_ZERO;
    spread = 600;
    lo = 0;
    hi = 0;
    case (kind)
      VK_REST: begin
        lo = 3000;
        hi = 5000;
      end
      VK_STRONG: begin
        lo = 8500;
        hi = 12500;
      end
      VK_IMPACT: begin
        lo = 12600;
        hi = 32767;
        spread = 2000;
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      case (kind)
        VK_ZERO: axis[i] = '0;
        VK_ANY:  axis[i] = 16'($urandom);
        VK_EXTREME: begin
          case ($urandom_range(0, 3))
            0: axis[i] = 16'h8000;
            1: axis[i] = 16'h7fff;
            2: axis[i] = 16'h0000;
            default: axis[i] = 16'hffff;
          endcase
        end
        default: axis[i] = 16'($urandom_range(0, 2 * spread) - spread);
      endcase
    end
    // one dominant axis carries the intended magnitude
    if (lo != 0) begin
      lead = $urandom_range(0, 2);
      mag = $urandom_range(lo, hi);
      axis[lead] = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    end
    v.x = axis[0];
    v.y = axis[1];
    v.z = axis[2];
    return v;
  endfunction

  task automatic send_request(logic f, accel_t v, logic [31:0] t);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    accel_x_i  <= v.x;
    accel_y_i  <= v.y;
    accel_z_i  <= v.z;
    time_ms_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_sample(accel_t v, int unsigned step_lo, int unsigned step_hi);
    now_ms += $urandom_range(step_lo, step_hi);
    send_request(1'b0, v, now_ms);
  endtask

  task automatic send_rearm();
    send_request(1'b1, pick_vector(VK_ANY), $urandom);
  endtask

  task automatic settle(int unsigned tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (phase_report_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_thresholds(logic [31:0] cand, logic [31:0] hit,
                                  logic signed [15:0] cos, logic [31:0] low,
                                  logic [31:0] high);
    write_reg(CFG_CAND_MAG, cand);
    write_reg(CFG_IMPACT_MAG, hit);
    write_reg(CFG_ORIENT_COS, {{16{cos[15]}}, cos});
    write_reg(CFG_REST_LOW, low);
    write_reg(CFG_REST_HIGH, high);
  endtask

  // well-formed walk toward a fall with random content and timing
  task automatic run_fall_attempt();
    vec_kind_e lead_kind;
    repeat ($urandom_range(0, 3)) send_sample(pick_vector(VK_REST), 5, 50);
    case ($urandom_range(0, 4))
      0, 1: lead_kind = VK_STRONG;
      2, 3: lead_kind = VK_IMPACT;
      default: lead_kind = VK_EXTREME;
    endcase
    send_sample(pick_vector(lead_kind), 5, 50);
    repeat ($urandom_range(0, 2)) send_sample(pick_vector(VK_REST), 10, 200);
    send_sample(pick_vector(VK_IMPACT), 10, ($urandom_range(0, 9) == 0) ? 700 : 300);
    repeat ($urandom_range(1, 3)) begin
      send_sample(pick_vector($urandom_range(0, 1) ? VK_ANY : VK_REST), 1,
                  ($urandom_range(0, 7) == 0) ? 1300 : 200);
    end
    send_sample(pick_vector(VK_ANY), 10, 100);
    repeat ($urandom_range(3, 10)) begin
      send_sample(pick_vector(($urandom_range(0, 6) == 0) ? VK_ANY : VK_REST), 100, 500);
    end
    repeat ($urandom_range(0, 2)) send_sample(pick_vector(VK_ANY), 10, 300);
    if ($urandom_range(0, 9) < 6) send_rearm();
  endtask

  task automatic run_noise(int count);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: send_rearm();
        1: begin
          now_ms = $urandom;
          send_request(1'b0, pick_vector(VK_ANY), now_ms);
        end
        2: begin
          // timestamp running backwards
          now_ms = now_ms - $urandom_range(1, 100);
          send_request(1'b0, pick_vector(VK_EXTREME), now_ms);
        end
        default: send_sample(pick_vector(vec_kind_e'($urandom_range(0, 5))), 0, 600);
      endcase
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    send_request(1'b0, axes(0, 0, 4096), 32'd0);
    send_request(1'b1, axes(-32768, 32767, -1), 32'hffff_ffff);
    send_request(1'b0, axes(0, 0, 0), 32'd10);
    // extremes through candidate and impact, then a full fall
    send_request(1'b0, axes(32767, 32767, 32767), 32'd20);
    send_request(1'b0, axes(-32768, -32768, -32768), 32'd30);
    send_request(1'b0, axes(0, 0, 4096), 32'd40);
    send_request(1'b0, axes(-32768, 0, 0), 32'd50);
    send_request(1'b0, axes(0, 4096, 0), 32'd1000);
    send_request(1'b0, axes(0, 4096, 0), 32'd1540);
    send_request(1'b0, axes(32767, 32767, 32767), 32'd1600);
    send_request(1'b1, axes(0, 0, 0), 32'd0);
    // candidate timeout across the timestamp wrap
    send_request(1'b0, axes(0, 0, 10000), 32'hffff_ff00);
    send_request(1'b0, axes(0, 0, 4096), 32'h0000_00f0);
    send_request(1'b0, axes(0, 0, 4096), 32'h0000_00f5);
    // same direction before and after impact, so impact times out
    send_request(1'b0, axes(0, 0, 10000), 32'd100);
    send_request(1'b0, axes(0, 0, 13000), 32'd200);
    send_request(1'b0, axes(0, 0, 4096), 32'd1200);
    send_request(1'b0, axes(0, 0, 4096), 32'd1201);
    // inactivity check times out
    send_request(1'b0, axes(0, 0, 10000), 32'd2000);
    send_request(1'b0, axes(13000, 0, 0), 32'd2100);
    send_request(1'b0, axes(0, 0, 4096), 32'd2200);
    send_request(1'b0, axes(0, 0, 4096), 32'd2300);
    send_request(1'b0, axes(0, 0, 0), 32'd5201);
    send_request(1'b0, axes(0, 0, 10000), 32'd5300);
    send_request(1'b0, axes(0, 0, 4096), 32'd5299);
    now_ms = 32'd6000;
    settle(4);
  endtask

  task automatic test_default_random();
    for (int k = 0; k < 35; k++) begin
      idle_on = (k % 10) >= 3;
      run_fall_attempt();
      if (k % 5 == 4) run_noise(12);
    end
    settle(4);
  endtask

  task automatic test_zero_vectors();
    logic signed [15:0] cos_pick;
    idle_on = 1'b1;
    zero_bias_pct = 35;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: cos_pick = COS_ONE;
        1: cos_pick = ORIENT_COS_RST;
        default: cos_pick = COS_ONE + 16'sd1;
      endcase
      write_thresholds('0, '0, cos_pick, REST_LOW_RST, REST_HIGH_RST);
      repeat (5) run_fall_attempt();
      settle(4);
    end
    zero_bias_pct = 3;
  endtask

  task automatic test_threshold_sweep();
    logic signed [15:0] cos_pick;
    idle_on = 1'b1;
    for (int k = 0; k < 8; k++) begin
      cos_pick = 16'($urandom_range(0, 32768) - 16384);
      case (k)
        0: write_thresholds('0, '0, -COS_ONE, '0, '0);
        1: write_thresholds(THR_MAX, THR_MAX, COS_ONE, THR_MAX, THR_MAX);
        2: write_thresholds(CAND_MAG_RST, IMPACT_MAG_RST, 16'sh7fff, REST_LOW_RST,
                            REST_HIGH_RST);
        3: write_thresholds(CAND_MAG_RST, IMPACT_MAG_RST, 16'sh8000, REST_LOW_RST,
                            REST_HIGH_RST);
        // empty rest band
        4: write_thresholds(CAND_MAG_RST, IMPACT_MAG_RST, 16'sd0, REST_HIGH_RST,
                            REST_LOW_RST);
        5: write_thresholds($urandom_range(0, 2 * CAND_MAG_RST),
                            $urandom_range(0, 2 * IMPACT_MAG_RST), cos_pick,
                            $urandom_range(0, REST_LOW_RST),
                            $urandom_range(REST_LOW_RST, 2 * REST_HIGH_RST));
        6: write_thresholds($urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX),
                            cos_pick, $urandom_range(0, THR_MAX),
                            $urandom_range(0, THR_MAX));
        default: write_thresholds(CAND_MAG_RST, IMPACT_MAG_RST, ORIENT_COS_RST,
                                  REST_LOW_RST, REST_HIGH_RST);
      endcase
      repeat (6) run_fall_attempt();
      run_noise(20);
      settle(4);
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = 1'b0;
    accel_x_i     = '0;
    accel_y_i     = '0;
    accel_z_i     = '0;
    time_ms_i     = '0;
    out_ready_i   = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CAND_MAG;
    cfg_data_i    = '0;
    fail_count    = 0;
    idle_on       = 1'b0;
    stall_left    = 0;
    zero_bias_pct = 3;
    now_ms        = '0;
    reset_model();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_default_random();
    test_zero_vectors();
    test_threshold_sweep();
    settle(40);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
